// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by mrb_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define MRB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies expression in the next.
`define MRB_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

// ===== hw/rtl/mrb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrb_pkg
// Types, widths and codes of the modal resonator bank.
// ----------------------------------------------------------------------------
package mrb_pkg;

    localparam int MAX_MODES = 64;
    localparam int MODE_AW   = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int CNT_W     = $clog2(MAX_MODES + 1);

    localparam int CMD_W     = 2;
    localparam int SMP_W     = 24;
    localparam int IDX_W     = 6;
    localparam int COEF_W    = 32;
    localparam int HIST_W    = 40;
    localparam int GAIN_W    = 18;
    localparam int ACT_W     = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN     = 2'd2;

    localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    localparam logic signed [GAIN_W-1:0] DRY_RESET = 18'sd65536;
    localparam logic signed [GAIN_W-1:0] MIX_RESET = 18'sd58982;

    // mode datapath
    localparam int HSPLIT     = 20;
    localparam int PPH_W      = COEF_W + HIST_W - HSPLIT;
    localparam int PPL_W      = COEF_W + HSPLIT + 1;
    localparam int PROD_W     = COEF_W + HIST_W;
    localparam int FRAC_SHIFT = 30;
    localparam int TERM_W     = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = TERM_W + 2;
    localparam int MODAL_W    = TERM_W + CNT_W;

    // output datapath
    localparam int MSPLIT     = 24;
    localparam int MIXH_W     = GAIN_W + MODAL_W - MSPLIT;
    localparam int MIXL_W     = GAIN_W + MSPLIT + 1;
    localparam int MIXF_W     = GAIN_W + MODAL_W;
    localparam int GAIN_SHIFT = 16;
    localparam int MIXT_W     = MIXF_W - GAIN_SHIFT;
    localparam int DRY_W      = GAIN_W + SMP_W;
    localparam int DRYT_W     = DRY_W - GAIN_SHIFT;
    localparam int RES_W      = MIXT_W + 1;

    localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
    localparam logic signed [SMP_W-1:0]  OUT_MAX  = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0]  OUT_MIN  = {1'b1, {(SMP_W-1){1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [SMP_W-1:0]  sample_in;
        logic [IDX_W-1:0]         mode_index;
        logic signed [COEF_W-1:0] feedback_one;
        logic signed [COEF_W-1:0] feedback_two;
        logic signed [COEF_W-1:0] mode_weight;
    } t_in_req;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    clipped;
    } t_out_res;

    typedef struct packed {
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] w;
    } t_coef;

    typedef struct packed {
        logic signed [HIST_W-1:0] y1;
        logic signed [HIST_W-1:0] y2;
    } t_hist;

endpackage

// ===== hw/rtl/modal_resonator_bank_unit.sv =====
// ----------------------------------------------------------------------------
// modal_resonator_bank_unit
// Time-multiplexed bank of two-pole resonators, coefficients and histories in RAM.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------
//  in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_req)
//  out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out_res)
//  cfg      | input     | i_cfg_we, write only       | i_cfg_idx, i_cfg_data
//
//  Process request: the bank is busy from accept until the result is loaded
//  into the output register; it processes N = min(active_modes, MAX_MODES)
//  modes, and one mode enters the read-modify-write pipeline per cycle.
//  Load and clear keep the bank idle. Clear resets per-mode valid bits.
//  Reset is synchronous; coefficient RAM contents are undefined until loaded.
//  A finished sample waits in the output register; a process request stalls
//  in its last step while that register is still full.
// ----------------------------------------------------------------------------
module modal_resonator_bank_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mrb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mrb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mrb_pkg::t_in_req                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mrb_pkg::t_out_res                  o_out_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_FIN1  = 3'd3;
    localparam logic [2:0] ST_FIN2  = 3'd4;
    localparam logic [2:0] ST_FIN3  = 3'd5;

    // configuration
    logic [mrb_pkg::ACT_W-1:0]         r_active_modes;
    logic signed [mrb_pkg::GAIN_W-1:0] r_dry_gain;
    logic signed [mrb_pkg::GAIN_W-1:0] r_mix_gain;

    // control
    logic [2:0]                        r_state, n_state;
    logic [mrb_pkg::CNT_W-1:0]         r_k, r_n;
    logic [mrb_pkg::MAX_MODES-1:0]     r_hist_vld;
    logic                              r_s1_vld, r_s2_vld, r_s3_vld;
    logic                              r_s4_vld, r_s5_vld, r_s6_vld;
    logic                              r_clip;
    logic                              r_out_vld;

    // memories
    mrb_pkg::t_coef                    r_coef_mem [mrb_pkg::MAX_MODES];
    mrb_pkg::t_hist                    r_hist_mem [mrb_pkg::MAX_MODES];
    mrb_pkg::t_coef                    r_coef_rd;
    mrb_pkg::t_hist                    r_hist_rd;

    // pipeline payload
    logic signed [mrb_pkg::SMP_W-1:0]  r_x;
    logic                              r_s1_hv;
    logic [mrb_pkg::MODE_AW-1:0]       r_s1_k, r_s2_k, r_s3_k, r_s4_k;
    logic signed [mrb_pkg::PPH_W-1:0]  r_s2_pp1h, r_s2_pp2h;
    logic signed [mrb_pkg::PPL_W-1:0]  r_s2_pp1l, r_s2_pp2l;
    logic signed [mrb_pkg::HIST_W-1:0] r_s2_y1, r_s3_y1, r_s4_y1, r_s4_y;
    logic signed [mrb_pkg::COEF_W-1:0] r_s2_w, r_s3_w, r_s4_w;
    logic signed [mrb_pkg::TERM_W-1:0] r_s3_p1, r_s3_p2, r_s6_term;
    logic signed [mrb_pkg::PPH_W-1:0]  r_s5_wh;
    logic signed [mrb_pkg::PPL_W-1:0]  r_s5_wl;
    logic signed [mrb_pkg::MODAL_W-1:0] r_modal;
    logic signed [mrb_pkg::MIXH_W-1:0] r_mix_h;
    logic signed [mrb_pkg::MIXL_W-1:0] r_mix_l;
    logic signed [mrb_pkg::DRY_W-1:0]  r_dry;
    logic signed [mrb_pkg::MIXT_W-1:0] r_mixt;
    logic signed [mrb_pkg::DRYT_W-1:0] r_dryt;
    mrb_pkg::t_out_res                 r_out;

    // combinational
    logic                              w_accept, w_proc, w_load, w_clear, w_issue;
    logic                              w_busy, w_out_load, w_res_ovf;
    logic [mrb_pkg::CNT_W-1:0]         w_n;
    logic [mrb_pkg::MODE_AW-1:0]       w_k_addr, w_load_addr;
    logic signed [mrb_pkg::HIST_W-1:0] w_y1, w_y2, w_y;
    logic signed [mrb_pkg::PROD_W-1:0] w_f1, w_f2, w_fw;
    logic signed [mrb_pkg::SUM_W-1:0]  w_sum;
    logic                              w_ovf;
    logic signed [mrb_pkg::MIXF_W-1:0] w_mixf;
    logic signed [mrb_pkg::RES_W-1:0]  w_res;
    logic signed [mrb_pkg::SMP_W-1:0]  w_res_sat;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_proc      = w_accept && (i_in_data.command == mrb_pkg::CMD_PROCESS);
    assign w_load      = w_accept && (i_in_data.command == mrb_pkg::CMD_LOAD)
                         && (int'(i_in_data.mode_index) < mrb_pkg::MAX_MODES);
    assign w_clear     = w_accept && (i_in_data.command == mrb_pkg::CMD_CLEAR);
    assign w_issue     = (r_state == ST_RUN) && (r_k != r_n);
    assign w_k_addr    = r_k[mrb_pkg::MODE_AW-1:0];
    assign w_load_addr = mrb_pkg::MODE_AW'(i_in_data.mode_index);
    assign w_busy      = r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld || r_s5_vld
                         || r_s6_vld;
    assign w_out_load  = (r_state == ST_FIN3) && (!r_out_vld || i_out_ready);
    assign w_n         = (int'(r_active_modes) > mrb_pkg::MAX_MODES)
                         ? mrb_pkg::CNT_W'(mrb_pkg::MAX_MODES)
                         : mrb_pkg::CNT_W'(r_active_modes);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_proc) n_state = ST_RUN;
            ST_RUN:   if (!w_issue) n_state = ST_DRAIN;
            ST_DRAIN: if (!w_busy) n_state = ST_FIN1;
            ST_FIN1:  n_state = ST_FIN2;
            ST_FIN2:  n_state = ST_FIN3;
            ST_FIN3:  if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // mode datapath
    always_comb begin
        w_y1 = r_s1_hv ? r_hist_rd.y1 : '0;
        w_y2 = r_s1_hv ? r_hist_rd.y2 : '0;
        w_f1 = (mrb_pkg::PROD_W'(r_s2_pp1h) <<< mrb_pkg::HSPLIT)
               + mrb_pkg::PROD_W'(r_s2_pp1l);
        w_f2 = (mrb_pkg::PROD_W'(r_s2_pp2h) <<< mrb_pkg::HSPLIT)
               + mrb_pkg::PROD_W'(r_s2_pp2l);
        w_sum = mrb_pkg::SUM_W'(r_x) + mrb_pkg::SUM_W'(r_s3_p1)
                - mrb_pkg::SUM_W'(r_s3_p2);
        w_ovf = (w_sum[mrb_pkg::SUM_W-1:mrb_pkg::HIST_W-1]
                 != {(mrb_pkg::SUM_W-mrb_pkg::HIST_W+1){w_sum[mrb_pkg::SUM_W-1]}});
        if (w_ovf) begin
            w_y = w_sum[mrb_pkg::SUM_W-1] ? mrb_pkg::HIST_MIN : mrb_pkg::HIST_MAX;
        end else begin
            w_y = w_sum[mrb_pkg::HIST_W-1:0];
        end
        w_fw = (mrb_pkg::PROD_W'(r_s5_wh) <<< mrb_pkg::HSPLIT)
               + mrb_pkg::PROD_W'(r_s5_wl);
    end

    // output datapath
    always_comb begin
        w_mixf = (mrb_pkg::MIXF_W'(r_mix_h) <<< mrb_pkg::MSPLIT)
                 + mrb_pkg::MIXF_W'(r_mix_l);
        w_res  = mrb_pkg::RES_W'(r_mixt) + mrb_pkg::RES_W'(r_dryt);
        w_res_ovf = (w_res[mrb_pkg::RES_W-1:mrb_pkg::SMP_W-1]
                     != {(mrb_pkg::RES_W-mrb_pkg::SMP_W+1){w_res[mrb_pkg::RES_W-1]}});
        if (w_res_ovf) begin
            w_res_sat = w_res[mrb_pkg::RES_W-1] ? mrb_pkg::OUT_MIN : mrb_pkg::OUT_MAX;
        end else begin
            w_res_sat = w_res[mrb_pkg::SMP_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_modes <= '0;
            r_dry_gain     <= mrb_pkg::DRY_RESET;
            r_mix_gain     <= mrb_pkg::MIX_RESET;
            r_state        <= ST_IDLE;
            r_hist_vld     <= '0;
            r_s1_vld       <= 1'b0;
            r_s2_vld       <= 1'b0;
            r_s3_vld       <= 1'b0;
            r_s4_vld       <= 1'b0;
            r_s5_vld       <= 1'b0;
            r_s6_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mrb_pkg::CFG_ACTIVE_MODES:
                        r_active_modes <= i_cfg_data[mrb_pkg::ACT_W-1:0];
                    mrb_pkg::CFG_DRY_GAIN: r_dry_gain <= i_cfg_data;
                    mrb_pkg::CFG_MIX_GAIN: r_mix_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state  <= n_state;
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            if (w_clear) begin
                r_hist_vld <= '0;
            end else if (r_s4_vld) begin
                r_hist_vld[r_s4_k] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // coefficient RAM
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_coef_mem[w_load_addr] <= '{a1: i_in_data.feedback_one,
                                         a2: i_in_data.feedback_two,
                                         w:  i_in_data.mode_weight};
        end
        if (w_issue) begin
            r_coef_rd <= r_coef_mem[w_k_addr];
        end
    end

    // history RAM
    always_ff @(posedge i_clk) begin
        if (r_s4_vld) begin
            r_hist_mem[r_s4_k] <= '{y1: r_s4_y, y2: r_s4_y1};
        end
        if (w_issue) begin
            r_hist_rd <= r_hist_mem[w_k_addr];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_x     <= i_in_data.sample_in;
            r_n     <= w_n;
            r_k     <= '0;
            r_modal <= '0;
            r_clip  <= 1'b0;
        end else begin
            if (w_issue) r_k <= r_k + 1'b1;
            if (r_s3_vld && w_ovf) r_clip <= 1'b1;
            if (r_s6_vld) r_modal <= r_modal + mrb_pkg::MODAL_W'(r_s6_term);
        end

        r_s1_hv <= r_hist_vld[w_k_addr];
        r_s1_k  <= w_k_addr;

        r_s2_pp1h <= r_coef_rd.a1
                     * $signed(w_y1[mrb_pkg::HIST_W-1:mrb_pkg::HSPLIT]);
        r_s2_pp1l <= r_coef_rd.a1 * $signed({1'b0, w_y1[mrb_pkg::HSPLIT-1:0]});
        r_s2_pp2h <= r_coef_rd.a2
                     * $signed(w_y2[mrb_pkg::HIST_W-1:mrb_pkg::HSPLIT]);
        r_s2_pp2l <= r_coef_rd.a2 * $signed({1'b0, w_y2[mrb_pkg::HSPLIT-1:0]});
        r_s2_y1   <= w_y1;
        r_s2_w    <= r_coef_rd.w;
        r_s2_k    <= r_s1_k;

        r_s3_p1 <= w_f1[mrb_pkg::PROD_W-1:mrb_pkg::FRAC_SHIFT];
        r_s3_p2 <= w_f2[mrb_pkg::PROD_W-1:mrb_pkg::FRAC_SHIFT];
        r_s3_y1 <= r_s2_y1;
        r_s3_w  <= r_s2_w;
        r_s3_k  <= r_s2_k;

        r_s4_y  <= w_y;
        r_s4_y1 <= r_s3_y1;
        r_s4_w  <= r_s3_w;
        r_s4_k  <= r_s3_k;

        r_s5_wh <= r_s4_w * $signed(r_s4_y[mrb_pkg::HIST_W-1:mrb_pkg::HSPLIT]);
        r_s5_wl <= r_s4_w * $signed({1'b0, r_s4_y[mrb_pkg::HSPLIT-1:0]});

        r_s6_term <= w_fw[mrb_pkg::PROD_W-1:mrb_pkg::FRAC_SHIFT];

        r_mix_h <= r_mix_gain
                   * $signed(r_modal[mrb_pkg::MODAL_W-1:mrb_pkg::MSPLIT]);
        r_mix_l <= r_mix_gain * $signed({1'b0, r_modal[mrb_pkg::MSPLIT-1:0]});
        r_dry   <= r_dry_gain * r_x;

        r_mixt <= w_mixf[mrb_pkg::MIXF_W-1:mrb_pkg::GAIN_SHIFT];
        r_dryt <= r_dry[mrb_pkg::DRY_W-1:mrb_pkg::GAIN_SHIFT];

        if (w_out_load) begin
            r_out.sample_out <= w_res_sat;
            r_out.clipped    <= r_clip || w_res_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/mrb_checker.sv =====
// ----------------------------------------------------------------------------
// mrb_checker
// Port-level checks of the modal resonator bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input mrb_pkg::t_in_req  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input mrb_pkg::t_out_res o_out_data
);

    `MRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `MRB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data), "result changed while stalled")
    `MRB_ASSERT_NEXT(a_proc_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_data.command == mrb_pkg::CMD_PROCESS), !o_in_ready, "process request did not occupy the bank")
    `MRB_ASSERT_NEXT(a_other_ready, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_data.command != mrb_pkg::CMD_PROCESS), o_in_ready, "load or clear request blocked the input")
    `MRB_ASSERT(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> !$past(o_in_ready), "result appeared without a process request in flight")

endmodule

bind modal_resonator_bank_unit mrb_checker u_mrb_checker (.*);
